FILE: design/tec_pkg.sv
package tec_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_CORDIC,
        ST_POST,
        ST_HOLD
    } state_t;

    typedef logic [1:0] cfg_index_t;
    typedef logic [4:0] count_t;

    localparam cfg_index_t CFG_SAMPLE_PERIOD = 2'd0;
    localparam cfg_index_t CFG_BLEND_WEIGHT  = 2'd1;

    localparam count_t SQ_LAST          = 5'd3;
    localparam count_t ROOT_LAST        = 5'd31;
    localparam count_t CORDIC_LAST      = 5'd29;
    localparam count_t POST_LAST_RAW    = 5'd5;
    localparam count_t POST_LAST_FILT   = 5'd11;

    localparam logic [16:0] WEIGHT_ONE  = 17'd65536;
    localparam logic [29:0] DEG_PER_RAD = 30'd961263669;

    typedef struct packed {
        logic               operation;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [31:0] rate_x;
        logic signed [31:0] rate_y;
        logic               sensor_ok;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] pitch_out;
        logic signed [31:0] roll_out;
        logic               status;
    } result_t;

    function automatic logic signed [31:0] atan_step(input count_t i);
        logic signed [31:0] t;
        unique case (i)
            5'd0:    t = 32'sd421657428;
            5'd1:    t = 32'sd248918915;
            5'd2:    t = 32'sd131521918;
            5'd3:    t = 32'sd66762579;
            5'd4:    t = 32'sd33510843;
            5'd5:    t = 32'sd16771758;
            5'd6:    t = 32'sd8387925;
            5'd7:    t = 32'sd4194219;
            5'd8:    t = 32'sd2097141;
            5'd9:    t = 32'sd1048575;
            default: t = 32'sd1 <<< (5'd29 - i);
        endcase
        return t;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // round half up, then arithmetic shift right
    function automatic logic signed [65:0] rnd_shift(input logic signed [65:0] v,
                                                     input int sh);
        logic signed [65:0] r;
        r = (v + (66'sd1 <<< (sh - 1))) >>> sh;
        return r;
    endfunction

endpackage

FILE: design/tec_if.sv
interface tec_sample_if;
    import tec_pkg::*;
    logic    valid;
    logic    ready;
    sample_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tec_result_if;
    import tec_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tec_cfg_if;
    import tec_pkg::*;
    logic        valid;
    logic        ready;
    cfg_index_t  index;
    logic [23:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/tilt_estimator_complementary_top.sv
// Tilt estimator: accel tilt angles via a 32-step square root and 30-step
// CORDIC (pitch and roll lanes run side by side), gyro integration and
// complementary blending through one shared 33x33 multiplier. Filtered mode
// spends longer in post-processing than raw mode. The square root and CORDIC
// iterations take most of the time per word. A new word is taken once the
// previous result has moved to the output register.
module tilt_estimator_complementary_top
    import tec_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    tec_sample_if.sink    sample,
    tec_result_if.source  result,
    tec_cfg_if.sink       cfg
);

    state_t state_reg, state_next;
    count_t cnt_reg, cnt_next;

    logic [23:0]        period_reg;
    logic [16:0]        weight_reg;
    sample_t            in_reg;
    logic signed [31:0] gps_reg, grs_reg, fap_reg, far_reg, fgp_reg, fgr_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_reg, acc_reg;
    logic [31:0]        sqx_reg, sqy_reg;

    logic [63:0]        rad_reg  [2];
    logic [35:0]        rem_reg  [2];
    logic [31:0]        root_reg [2];
    logic [35:0]        rem_nx   [2];
    logic [31:0]        root_nx  [2];
    logic signed [35:0] x_reg [2], y_reg [2];
    logic signed [31:0] z_reg [2];
    logic signed [35:0] x_nx [2], y_nx [2];
    logic signed [31:0] z_nx [2];
    logic               zero_reg [2];
    logic signed [31:0] ang_reg [2];

    logic signed [32:0] stepx_reg, stepy_reg, degp_reg, degr_reg;
    logic signed [31:0] po_reg, ro_reg;
    logic               res_valid_reg;
    result_t            res_data_reg;

    logic [16:0] w_eff, w_inv;
    logic        load_out;
    count_t      post_last;

    assign w_eff     = (weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : weight_reg;
    assign w_inv     = WEIGHT_ONE - w_eff;
    assign post_last = in_reg.operation ? POST_LAST_FILT : POST_LAST_RAW;
    assign load_out  = (state_reg == ST_HOLD) && (!res_valid_reg || result.ready);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (sample.valid) state_next = ST_SQUARE;
            ST_SQUARE: if (cnt_reg == SQ_LAST) state_next = ST_ROOT;
            ST_ROOT:   if (cnt_reg == ROOT_LAST) state_next = ST_CORDIC;
            ST_CORDIC: if (cnt_reg == CORDIC_LAST) state_next = ST_POST;
            ST_POST:   if (cnt_reg == post_last) state_next = ST_HOLD;
            ST_HOLD:   if (load_out) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
        cnt_next = (state_next != state_reg) ? 5'd0 : cnt_reg + 5'd1;
    end

    always_comb
    begin
        sample.ready = (state_reg == ST_IDLE);
        cfg.ready    = 1'b1;
        result.valid = res_valid_reg;
        result.data  = res_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_SQUARE)
        begin
            unique case (cnt_reg)
                5'd0:    begin mul_a = 33'(in_reg.accel_x); mul_b = 33'(in_reg.accel_x); end
                5'd1:    begin mul_a = 33'(in_reg.accel_y); mul_b = 33'(in_reg.accel_y); end
                default: begin mul_a = 33'(in_reg.accel_z); mul_b = 33'(in_reg.accel_z); end
            endcase
        end
        else if (state_reg == ST_POST)
        begin
            unique case (cnt_reg)
                5'd0: begin mul_a = 33'(in_reg.rate_x); mul_b = {9'd0, period_reg}; end
                5'd1: begin mul_a = 33'(in_reg.rate_y); mul_b = {9'd0, period_reg}; end
                default:
                begin
                    if (!in_reg.operation)
                    begin
                        if (cnt_reg == 5'd2)
                        begin
                            mul_a = 33'(ang_reg[0]); mul_b = {3'd0, DEG_PER_RAD};
                        end
                        else
                        begin
                            mul_a = 33'(ang_reg[1]); mul_b = {3'd0, DEG_PER_RAD};
                        end
                    end
                    else
                    begin
                        unique case (cnt_reg)
                            5'd2:    begin mul_a = 33'(fap_reg);    mul_b = {16'd0, w_eff}; end
                            5'd3:    begin mul_a = 33'(ang_reg[0]); mul_b = {16'd0, w_inv}; end
                            5'd4:    begin mul_a = 33'(far_reg);    mul_b = {16'd0, w_eff}; end
                            5'd5:    begin mul_a = 33'(ang_reg[1]); mul_b = {16'd0, w_inv}; end
                            5'd6:    begin mul_a = 33'(fgp_reg);    mul_b = {16'd0, w_eff}; end
                            5'd7:    begin mul_a = 33'(fgr_reg);    mul_b = {16'd0, w_eff}; end
                            5'd8:    begin mul_a = 33'(fap_reg);    mul_b = {3'd0, DEG_PER_RAD}; end
                            default: begin mul_a = 33'(far_reg);    mul_b = {3'd0, DEG_PER_RAD}; end
                        endcase
                    end
                end
            endcase
        end
    end

    // square root and CORDIC lanes
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            logic [35:0] rsh, trial;
            logic signed [35:0] dx, dy;
            rsh   = {rem_reg[l][33:0], rad_reg[l][63:62]};
            trial = {2'd0, root_reg[l], 2'b01};
            if (rsh >= trial)
            begin
                rem_nx[l]  = rsh - trial;
                root_nx[l] = {root_reg[l][30:0], 1'b1};
            end
            else
            begin
                rem_nx[l]  = rsh;
                root_nx[l] = {root_reg[l][30:0], 1'b0};
            end
            dx = y_reg[l] >>> cnt_reg;
            dy = x_reg[l] >>> cnt_reg;
            if (y_reg[l] > 36'sd0)
            begin
                x_nx[l] = x_reg[l] + dx;
                y_nx[l] = y_reg[l] - dy;
                z_nx[l] = z_reg[l] + atan_step(cnt_reg);
            end
            else
            begin
                x_nx[l] = x_reg[l] - dx;
                y_nx[l] = y_reg[l] + dy;
                z_nx[l] = z_reg[l] - atan_step(cnt_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (sample.valid && sample.ready)
            in_reg <= sample.data;
        unique case (state_reg)
            ST_SQUARE:
            begin
                if (cnt_reg == 5'd1) sqx_reg <= prod_reg[31:0];
                if (cnt_reg == 5'd2) sqy_reg <= prod_reg[31:0];
                if (cnt_reg == SQ_LAST)
                begin
                    rad_reg[0] <= {sqy_reg + prod_reg[31:0], 32'd0};
                    rad_reg[1] <= {sqx_reg + prod_reg[31:0], 32'd0};
                    for (int l = 0; l < 2; l++)
                    begin
                        rem_reg[l]  <= '0;
                        root_reg[l] <= '0;
                    end
                end
            end
            ST_ROOT:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    rad_reg[l]  <= {rad_reg[l][61:0], 2'b00};
                    rem_reg[l]  <= rem_nx[l];
                    root_reg[l] <= root_nx[l];
                    z_reg[l]    <= '0;
                    x_reg[l]    <= {4'd0, root_nx[l]};
                end
                y_reg[0]    <= -(36'(in_reg.accel_x) <<< 16);
                y_reg[1]    <= -(36'(in_reg.accel_y) <<< 16);
                zero_reg[0] <= (root_nx[0] == 32'd0) && (in_reg.accel_x == 16'sd0);
                zero_reg[1] <= (root_nx[1] == 32'd0) && (in_reg.accel_y == 16'sd0);
            end
            ST_CORDIC:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    x_reg[l] <= x_nx[l];
                    y_reg[l] <= y_nx[l];
                    z_reg[l] <= z_nx[l];
                    if (cnt_reg == CORDIC_LAST)
                        ang_reg[l] <= zero_reg[l] ? 32'sd0 : z_nx[l];
                end
            end
            ST_POST:
            begin
                if (cnt_reg == 5'd1) stepx_reg <= 33'(rnd_shift(prod_reg, 24));
                if (cnt_reg == 5'd2) stepy_reg <= 33'(rnd_shift(prod_reg, 24));
                if (!in_reg.operation)
                begin
                    if (cnt_reg == 5'd3) degp_reg <= 33'(rnd_shift(prod_reg, 37));
                    if (cnt_reg == 5'd4) degr_reg <= 33'(rnd_shift(prod_reg, 37));
                    if (cnt_reg == POST_LAST_RAW)
                    begin
                        po_reg <= sat32(66'(gps_reg) + 66'(degp_reg));
                        ro_reg <= sat32(66'(grs_reg) + 66'(degr_reg));
                    end
                end
                else
                begin
                    if (cnt_reg == 5'd3 || cnt_reg == 5'd5) acc_reg <= prod_reg;
                    if (cnt_reg == 5'd9)  degp_reg <= 33'(rnd_shift(prod_reg, 37));
                    if (cnt_reg == 5'd10) degr_reg <= 33'(rnd_shift(prod_reg, 37));
                    if (cnt_reg == POST_LAST_FILT)
                    begin
                        po_reg <= sat32(66'(fgp_reg) + 66'(degp_reg));
                        ro_reg <= sat32(66'(fgr_reg) + 66'(degr_reg));
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            res_data_reg.pitch_out <= po_reg;
            res_data_reg.roll_out  <= ro_reg;
            res_data_reg.status    <= ~in_reg.sensor_ok;
        end
    end

    // filter and gyro state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gps_reg <= '0;
            grs_reg <= '0;
            fap_reg <= '0;
            far_reg <= '0;
            fgp_reg <= '0;
            fgr_reg <= '0;
        end
        else if (state_reg == ST_POST)
        begin
            if (cnt_reg == 5'd3)
            begin
                gps_reg <= sat32(66'(gps_reg) + 66'(stepx_reg));
                grs_reg <= sat32(66'(grs_reg) + 66'(stepy_reg));
            end
            if (in_reg.operation)
            begin
                if (cnt_reg == 5'd4) fap_reg <= sat32(rnd_shift(acc_reg + prod_reg, 16));
                if (cnt_reg == 5'd6) far_reg <= sat32(rnd_shift(acc_reg + prod_reg, 16));
                if (cnt_reg == 5'd7)
                    fgp_reg <= sat32(rnd_shift(prod_reg, 16) + 66'(stepy_reg));
                if (cnt_reg == 5'd8)
                    fgr_reg <= sat32(rnd_shift(prod_reg, 16) + 66'(stepx_reg));
            end
        end
    end

    // configuration and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= '0;
            weight_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    CFG_SAMPLE_PERIOD: period_reg <= cfg.data;
                    CFG_BLEND_WEIGHT:  weight_reg <= cfg.data[16:0];
                    default:
                    begin
                    end
                endcase
            end
            if (load_out)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> (state_reg == ST_SQUARE))
        else $error("sequencer did not start on accepted word");

    a_not_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROOT || state_reg == ST_CORDIC) |-> !sample.ready)
        else $error("ready while busy");

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HOLD && res_valid_reg && !result.ready) |=>
        (state_reg == ST_HOLD))
        else $error("result overwritten while output stalled");
`endif

endmodule

FILE: dv/tilt_estimator_complementary_top_tb.sv
`timescale 1ns / 1ps

module tilt_estimator_complementary_top_tb;
    import tec_pkg::*;

    logic clk;
    logic rst_n;

    tec_sample_if sample_ch ();
    tec_result_if result_ch ();
    tec_cfg_if    cfg_ch ();

    tilt_estimator_complementary_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch.sink),
        .result (result_ch.source),
        .cfg    (cfg_ch.sink)
    );

    // predictor state
    logic [23:0]        period_q;
    logic [16:0]        weight_q;
    logic signed [31:0] gsum_pitch, gsum_roll;
    logic signed [31:0] facc_pitch, facc_roll;
    logic signed [31:0] fgyr_pitch, fgyr_roll;

    result_t expected_q[$];
    int      mismatches;
    int      results_seen;
    bit      stall_hold;
    bit      burst_mode;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("tilt_estimator_complementary_top_tb NOT OK");
        $finish;
    end

    function automatic longint asr64(input longint v, input int sh);
        return v >>> sh;
    endfunction

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint floor_root(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    function automatic logic signed [31:0] tilt_angle(input longint axis, input longint a,
                                                     input longint b);
        longint y, x, z, t, dx, dy;
        logic [63:0] sq;
        y = -axis * 65536;
        sq = 64'(a * a + b * b) << 32;
        x = floor_root(sq);
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        for (int i = 0; i < 30; i++)
        begin
            case (i)
                0: t = 421657428;
                1: t = 248918915;
                2: t = 131521918;
                3: t = 66762579;
                4: t = 33510843;
                5: t = 16771758;
                6: t = 8387925;
                7: t = 4194219;
                8: t = 2097141;
                9: t = 1048575;
                default: t = longint'(1) << (29 - i);
            endcase
            dx = asr64(y, i);
            dy = asr64(x, i);
            if (y > 0)
            begin
                x = x + dx; y = y - dy; z = z + t;
            end
            else
            begin
                x = x - dx; y = y + dy; z = z - t;
            end
        end
        return clip32(z);
    endfunction

    function automatic longint rad_to_deg(input logic signed [31:0] rad);
        return asr64(longint'(rad) * 961263669 + (longint'(1) << 36), 37);
    endfunction

    function automatic longint rate_step(input logic signed [31:0] rate);
        return asr64(longint'(rate) * longint'(period_q) + (longint'(1) << 23), 24);
    endfunction

    task automatic predict_tilt(input sample_t s);
        logic signed [31:0] ap, ar;
        longint sx_step, sy_step, w, iw;
        result_t r;
        ap = tilt_angle(s.accel_x, s.accel_y, s.accel_z);
        ar = tilt_angle(s.accel_y, s.accel_x, s.accel_z);
        sx_step = rate_step(s.rate_x);
        sy_step = rate_step(s.rate_y);
        gsum_pitch = clip32(longint'(gsum_pitch) + sx_step);
        gsum_roll  = clip32(longint'(gsum_roll) + sy_step);
        if (s.operation == 1'b0)
        begin
            r.pitch_out = clip32(longint'(gsum_pitch) + rad_to_deg(ap));
            r.roll_out  = clip32(longint'(gsum_roll) + rad_to_deg(ar));
        end
        else
        begin
            w = (weight_q > WEIGHT_ONE) ? 65536 : longint'(weight_q);
            iw = 65536 - w;
            facc_pitch = clip32(asr64(w * facc_pitch + iw * ap + 32768, 16));
            facc_roll  = clip32(asr64(w * facc_roll + iw * ar + 32768, 16));
            fgyr_pitch = clip32(asr64(w * fgyr_pitch + 32768, 16) + sy_step);
            fgyr_roll  = clip32(asr64(w * fgyr_roll + 32768, 16) + sx_step);
            r.pitch_out = clip32(longint'(fgyr_pitch) + rad_to_deg(facc_pitch));
            r.roll_out  = clip32(longint'(fgyr_roll) + rad_to_deg(facc_roll));
        end
        r.status = ~s.sensor_ok;
        expected_q.push_back(r);
    endtask

    task automatic send_sample(input sample_t s);
        sample_ch.valid = 1'b1;
        sample_ch.data  = s;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        predict_tilt(s);
        @(negedge clk);
        sample_ch.valid = 1'b0;
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [23:0] val);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx == CFG_SAMPLE_PERIOD)
            period_q = val;
        else if (idx == CFG_BLEND_WEIGHT)
            weight_q = val[16:0];
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic drain_results();
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    function automatic sample_t random_sample();
        sample_t s;
        s.operation = 1'($urandom);
        s.sensor_ok = ($urandom_range(0, 9) != 0);
        case ($urandom_range(0, 3))
            0:
            begin
                s.accel_x = 16'($urandom);
                s.accel_y = 16'($urandom);
                s.accel_z = 16'($urandom);
            end
            1:
            begin
                s.accel_x = 16'($signed($urandom_range(0, 4000)) - 2000);
                s.accel_y = 16'($signed($urandom_range(0, 4000)) - 2000);
                s.accel_z = 16'sd16384 + 16'($urandom_range(0, 400));
            end
            2:
            begin
                s.accel_x = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
                s.accel_y = 16'($urandom_range(0, 3));
                s.accel_z = $urandom_range(0, 1) ? 16'sh8000 : 16'sh0000;
            end
            default:
            begin
                s.accel_x = 16'($signed($urandom_range(0, 20)) - 10);
                s.accel_y = 16'($signed($urandom_range(0, 20)) - 10);
                s.accel_z = 16'($signed($urandom_range(0, 20)) - 10);
            end
        endcase
        if ($urandom_range(0, 3) == 0)
        begin
            s.rate_x = $urandom;
            s.rate_y = $urandom;
        end
        else
        begin
            s.rate_x = 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
            s.rate_y = 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
        end
        return s;
    endfunction

    task automatic send_random(input int count);
        int burst;
        int sent;
        sent = 0;
        while (sent < count)
        begin
            burst = burst_mode ? count : $urandom_range(1, 12);
            for (int i = 0; i < burst && sent < count; i++)
            begin
                send_sample(random_sample());
                sent++;
            end
            if (!burst_mode)
                repeat ($urandom_range(0, 90)) @(negedge clk);
        end
    endtask

    task automatic test_directed();
        sample_t s;
        s = '0;
        s.sensor_ok = 1'b1;
        send_sample(s);
        s.operation = 1'b1;
        send_sample(s);
        s.sensor_ok = 1'b0;
        s.accel_z = 16'sd16384;
        send_sample(s);
        s.accel_x = 16'sh8000; s.accel_y = 16'sh8000; s.accel_z = 16'sh8000;
        s.rate_x = 32'sh7fffffff; s.rate_y = 32'sh80000000;
        s.operation = 1'b0;
        send_sample(s);
        s.accel_x = 16'sh7fff; s.accel_y = 16'sh7fff; s.accel_z = 16'sh7fff;
        s.rate_x = 32'sh80000000; s.rate_y = 32'sh7fffffff;
        send_sample(s);
        s.operation = 1'b1;
        s.sensor_ok = 1'b1;
        send_sample(s);
        s.accel_x = 16'sd0; s.accel_y = 16'sd100; s.accel_z = 16'sd0;
        send_sample(s);
        s.accel_x = 16'sd100; s.accel_y = 16'sd0; s.accel_z = 16'sd0;
        s.operation = 1'b0;
        send_sample(s);
        s.accel_x = -16'sd1; s.accel_y = 16'sd1; s.accel_z = -16'sd1;
        s.rate_x = -32'sd1; s.rate_y = 32'sd1;
        send_sample(s);
        drain_results();
    endtask

    task automatic test_saturation();
        sample_t s;
        write_reg(CFG_SAMPLE_PERIOD, 24'hffffff);
        write_reg(CFG_BLEND_WEIGHT, 24'h010000);
        s = '0;
        s.sensor_ok = 1'b1;
        s.rate_x = 32'sh7fffffff;
        s.rate_y = 32'sh80000000;
        for (int i = 0; i < 6; i++)
        begin
            s.operation = i[0];
            send_sample(s);
        end
        drain_results();
    endtask

    task automatic test_config_sweep();
        logic [23:0] periods[4];
        logic [23:0] weights[5];
        periods = '{24'd0, 24'd16777, 24'hffffff, 24'd167772};
        weights = '{24'd0, 24'd65536, 24'h01ffff, 24'd62259, 24'd32768};
        for (int i = 0; i < 5; i++)
        begin
            write_reg(CFG_SAMPLE_PERIOD, periods[i % 4]);
            write_reg(CFG_BLEND_WEIGHT, weights[i]);
            write_reg(cfg_index_t'(2 + (i & 1)), 24'($urandom));
            send_random(300);
            drain_results();
        end
    endtask

    task automatic test_back_pressure();
        write_reg(CFG_SAMPLE_PERIOD, 24'($urandom));
        write_reg(CFG_BLEND_WEIGHT, 24'($urandom_range(0, 65536)));
        stall_hold = 1'b1;
        burst_mode = 1'b1;
        fork
            send_random(40);
            begin
                repeat (600) @(negedge clk);
                stall_hold = 1'b0;
            end
        join
        burst_mode = 1'b0;
        drain_results();
        send_random(200);
        drain_results();
    endtask

    // receiver: stall pattern plus optional long hold
    initial
    begin
        int phase;
        result_ch.ready = 1'b0;
        phase = 0;
        forever
        begin
            @(negedge clk);
            phase++;
            if (stall_hold)
                result_ch.ready <= 1'b0;
            else if ((phase / 200) % 3 == 0)
                result_ch.ready <= 1'b1;
            else
                result_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial
    begin
        result_t exp_r;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word %h", result_ch.data);
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (result_ch.data !== exp_r)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: pitch %h/%h roll %h/%h status %b/%b",
                                     exp_r.pitch_out, result_ch.data.pitch_out,
                                     exp_r.roll_out, result_ch.data.roll_out,
                                     exp_r.status, result_ch.data.status);
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        sample_ch.valid = 1'b0;
        sample_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_SAMPLE_PERIOD;
        cfg_ch.data = '0;
        stall_hold = 1'b0;
        burst_mode = 1'b0;
        mismatches = 0;
        results_seen = 0;
        period_q = '0;
        weight_q = '0;
        gsum_pitch = 0; gsum_roll = 0;
        facc_pitch = 0; facc_roll = 0;
        fgyr_pitch = 0; fgyr_roll = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);
        test_directed();
        test_saturation();
        test_config_sweep();
        test_back_pressure();
        drain_results();
        if (mismatches == 0 && expected_q.size() == 0)
            $display("tilt_estimator_complementary_top_tb OK");
        else
            $display("tilt_estimator_complementary_top_tb NOT OK");
        $finish;
    end

endmodule
